// ===== sv/gwm_pkg.sv =====
package gwm_pkg;

	localparam int PAT_LIMIT       = 32;
	localparam int ACT_W_MAX       = PAT_LIMIT + 1;
	localparam int PATTERN_MAX_DEF = 32;

	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 6;
	localparam int INDEX_W = 3;
	localparam int LEN_W   = 6;
	localparam int CHAR_W  = 8;

	localparam logic [INDEX_W-1:0] REG_PAT0  = 3'd0;
	localparam logic [INDEX_W-1:0] REG_PAT1  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_PAT2  = 3'd2;
	localparam logic [INDEX_W-1:0] REG_PAT3  = 3'd3;
	localparam logic [INDEX_W-1:0] REG_LEN   = 3'd4;
	localparam logic [INDEX_W-1:0] REG_ICASE = 3'd5;

	localparam logic [CHAR_W-1:0] STAR_CHAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] ANY_CHAR   = 8'h3F;
	localparam logic [CHAR_W-1:0] LOWER_A    = 8'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z    = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

	typedef logic [ACT_W_MAX-1:0] act_vec_t;

	function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
		return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_DELTA : c;
	endfunction

	// prefix closure: prop bit j lets position j-1 reach position j (a star)
	function automatic act_vec_t star_close(input act_vec_t seed, input act_vec_t prop);
		act_vec_t g;
		act_vec_t p;
		g = seed;
		p = prop;
		for (int d = 1; d < ACT_W_MAX; d = d * 2) begin
			g = g | (p & (g << d));
			p = p & (p << d);
		end
		return g;
	endfunction

endpackage

// ===== sv/gwm_in_if.sv =====
interface gwm_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] subject_char;

	modport source(output valid, output kind, output subject_char, input ready);
	modport sink(input valid, input kind, input subject_char, output ready);
endinterface

// ===== sv/gwm_out_if.sv =====
interface gwm_out_if;
	logic valid;
	logic ready;
	logic matched;

	modport source(output valid, output matched, input ready);
	modport sink(input valid, input matched, output ready);
endinterface

// ===== sv/gwm_cfg.sv =====
module gwm_cfg #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      psel,
	input  logic                                      penable,
	input  logic                                      pwrite,
	input  logic [gwm_pkg::ADDR_W-1:0]                paddr,
	input  logic [gwm_pkg::DATA_W-1:0]                pwdata,
	output logic [gwm_pkg::DATA_W-1:0]                prdata,
	output logic                                      pready,
	output logic                                      cfg_wr,
	output logic [PATTERN_MAX:0]                      start_nx,
	output logic [PATTERN_MAX:0]                      start_q,
	output logic [PATTERN_MAX:0]                      fin_q,
	output logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0] pat_b_q,
	output logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0] pat_u_q,
	output logic [PATTERN_MAX-1:0]                    used_q,
	output logic [PATTERN_MAX-1:0]                    star_q,
	output logic [PATTERN_MAX-1:0]                    any_q,
	output logic                                      icase_q
);
	import gwm_pkg::*;

	localparam int PM = PATTERN_MAX;
	localparam int AW = PATTERN_MAX + 1;
	localparam logic [LEN_W-1:0] PM_LEN = LEN_W'(PATTERN_MAX);

	logic [3:0][DATA_W-1:0] pat_q;
	logic [LEN_W-1:0]       len_q;
	logic                   wr;
	logic [INDEX_W-1:0]     idx;
	logic [3:0][DATA_W-1:0] nx_pat;
	logic [LEN_W-1:0]       nx_len;
	logic                   nx_ic;
	logic [LEN_W-1:0]       lim;

	logic [PM-1:0][CHAR_W-1:0] b_nx;
	logic [PM-1:0][CHAR_W-1:0] u_nx;
	logic [PM-1:0]             nz;
	logic [PM-1:0]             used_nx;
	logic [PM-1:0]             star_nx;
	logic [PM-1:0]             any_nx;
	logic [AW-1:0]             fin_nx;
	act_vec_t                  start_full;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[ADDR_W-1:3];
	assign cfg_wr = wr && (idx <= REG_ICASE);

	always_comb begin
		nx_pat = pat_q;
		nx_len = len_q;
		nx_ic  = icase_q;
		if (wr) begin
			case (idx)
				REG_PAT0:  nx_pat[0] = pwdata;
				REG_PAT1:  nx_pat[1] = pwdata;
				REG_PAT2:  nx_pat[2] = pwdata;
				REG_PAT3:  nx_pat[3] = pwdata;
				REG_LEN:   nx_len    = pwdata[LEN_W-1:0];
				REG_ICASE: nx_ic     = pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PAT0:  prdata = pat_q[0];
			REG_PAT1:  prdata = pat_q[1];
			REG_PAT2:  prdata = pat_q[2];
			REG_PAT3:  prdata = pat_q[3];
			REG_LEN:   prdata = DATA_W'(len_q);
			REG_ICASE: prdata = DATA_W'(icase_q);
			default:   prdata = '0;
		endcase
	end

	assign lim = (nx_len > PM_LEN) ? PM_LEN : nx_len;

	// a position is in use below the length and before the first zero byte
	for (genvar g = 0; g < PM; g++) begin : g_pos
		assign b_nx[g]    = nx_pat[g / 8][(g % 8) * 8 +: 8];
		assign u_nx[g]    = to_upper(b_nx[g]);
		assign nz[g]      = (b_nx[g] != '0);
		assign used_nx[g] = (LEN_W'(g) < lim) && (&nz[g:0]);
		assign star_nx[g] = used_nx[g] && (b_nx[g] == STAR_CHAR);
		assign any_nx[g]  = used_nx[g] && (b_nx[g] == ANY_CHAR);
	end

	// one-hot mark of the effective pattern end
	assign fin_nx[0] = !used_nx[0];
	for (genvar j = 1; j < PM; j++) begin : g_fin
		assign fin_nx[j] = used_nx[j-1] && !used_nx[j];
	end
	assign fin_nx[PM] = used_nx[PM-1];

	assign start_full = star_close(ACT_W_MAX'(1), ACT_W_MAX'({star_nx, 1'b0}));
	assign start_nx   = start_full[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q   <= '0;
			len_q   <= '0;
			icase_q <= 1'b0;
			used_q  <= '0;
			star_q  <= '0;
			any_q   <= '0;
			fin_q   <= AW'(1);
			start_q <= AW'(1);
		end else begin
			pat_q   <= nx_pat;
			len_q   <= nx_len;
			icase_q <= nx_ic;
			used_q  <= used_nx;
			star_q  <= star_nx;
			any_q   <= any_nx;
			fin_q   <= fin_nx;
			start_q <= start_nx;
		end
	end

	always_ff @(posedge clk) begin
		pat_b_q <= b_nx;
		pat_u_q <= u_nx;
	end

	a_fin_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(fin_q))
		else $error("pattern end mark not one-hot");

	a_start_root: assert property (@(posedge clk) disable iff (!arst_n)
		start_q[0] && ((star_q & ~used_q) == '0))
		else $error("start set or star mask inconsistent");

endmodule

// ===== sv/gwm_step.sv =====
module gwm_step #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	gwm_in_if.sink                                      in_ch,
	gwm_out_if.source                                   mid,
	input  logic                                        cfg_wr,
	input  logic [PATTERN_MAX:0]                        start_nx,
	input  logic [PATTERN_MAX:0]                        start_q,
	input  logic [PATTERN_MAX:0]                        fin_q,
	input  logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0] pat_b_q,
	input  logic [PATTERN_MAX-1:0][gwm_pkg::CHAR_W-1:0] pat_u_q,
	input  logic [PATTERN_MAX-1:0]                      used_q,
	input  logic [PATTERN_MAX-1:0]                      star_q,
	input  logic [PATTERN_MAX-1:0]                      any_q,
	input  logic                                        icase_q
);
	import gwm_pkg::*;

	localparam int PM = PATTERN_MAX;
	localparam int AW = PATTERN_MAX + 1;

	logic              v_s1;
	logic              kind_s1;
	logic [CHAR_W-1:0] char_s1;
	logic [AW-1:0]     act_q;
	logic              adv;
	logic [CHAR_W-1:0] c_up;
	logic [PM-1:0]     hit;
	logic [AW-1:0]     step_raw;
	act_vec_t          closed;
	logic [AW-1:0]     act_nx;

	// a character item never waits on the result side
	assign adv         = !kind_s1 || mid.ready;
	assign in_ch.ready = !v_s1 || adv;
	assign mid.valid   = v_s1 && kind_s1;
	assign mid.matched = |(act_q & fin_q);

	assign c_up = to_upper(char_s1);

	for (genvar g = 0; g < PM; g++) begin : g_hit
		assign hit[g] = used_q[g] && !star_q[g] &&
			(any_q[g] || (pat_b_q[g] == char_s1) || (icase_q && (pat_u_q[g] == c_up)));
	end

	// stars hold their position, matches move one on
	assign step_raw = {1'b0, act_q[PM-1:0] & star_q} | {act_q[PM-1:0] & hit, 1'b0};
	assign closed   = star_close(ACT_W_MAX'(step_raw), ACT_W_MAX'({star_q, 1'b0}));
	assign act_nx   = closed[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			act_q <= AW'(1);
		end else begin
			if (in_ch.ready)
				v_s1 <= in_ch.valid;
			if (cfg_wr)
				act_q <= start_nx;
			else if (v_s1 && adv)
				act_q <= kind_s1 ? start_q : act_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1 <= in_ch.kind;
			char_s1 <= in_ch.subject_char;
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> (v_s1 && kind_s1 && !mid.ready))
		else $error("input stalled without a blocked end transfer");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && kind_s1 && mid.ready && !cfg_wr) |=> (act_q == $past(start_q)))
		else $error("active set not restarted after end of string");

	a_dead_set: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !kind_s1 && (act_q == '0) && !cfg_wr) |=> (act_q == '0))
		else $error("empty active set revived by a character");

endmodule

// ===== sv/gwm_out.sv =====
module gwm_out (
	input  logic       clk,
	input  logic       arst_n,
	gwm_out_if.sink    mid,
	gwm_out_if.source  out_ch
);
	logic v_q;
	logic matched_q;

	assign mid.ready      = !v_q || out_ch.ready;
	assign out_ch.valid   = v_q;
	assign out_ch.matched = matched_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (mid.ready) begin
			v_q <= mid.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mid.valid && mid.ready)
			matched_q <= mid.matched;
	end

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(mid.valid && mid.ready) |=> (out_ch.valid && (out_ch.matched == $past(mid.matched))))
		else $error("result transfer not captured in output register");

endmodule

// ===== sv/glob_wildcard_matcher_core.sv =====
// channel   dir   handshake         payload
// in_ch     in    valid / ready     kind, subject_char
// out_ch    out   valid / ready     matched (one per end-of-string item)
// apb       in    psel / penable    paddr 8*index, pwdata / prdata 64 bit
//
// one item per cycle unless an end item is held by a stalled output register; an item sits in the
// input register and its active-set update is done by one star-closure prefix network before the edge
// an end item's result appears on out_ch at the edge it leaves the input register
// reset brings the empty pattern in force: the start set is position zero only
// only an end item held by a stalled output register stops input transfers
module glob_wildcard_matcher_core #(
	parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	gwm_in_if.sink                     in_ch,
	gwm_out_if.source                  out_ch,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [gwm_pkg::ADDR_W-1:0] paddr,
	input  logic [gwm_pkg::DATA_W-1:0] pwdata,
	output logic [gwm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import gwm_pkg::*;

	logic                                cfg_wr;
	logic [PATTERN_MAX:0]                start_nx;
	logic [PATTERN_MAX:0]                start_q;
	logic [PATTERN_MAX:0]                fin_q;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0]  pat_b_q;
	logic [PATTERN_MAX-1:0][CHAR_W-1:0]  pat_u_q;
	logic [PATTERN_MAX-1:0]              used_q;
	logic [PATTERN_MAX-1:0]              star_q;
	logic [PATTERN_MAX-1:0]              any_q;
	logic                                icase_q;

	gwm_out_if mid();

	gwm_cfg #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg_wr   (cfg_wr),
		.start_nx (start_nx),
		.start_q  (start_q),
		.fin_q    (fin_q),
		.pat_b_q  (pat_b_q),
		.pat_u_q  (pat_u_q),
		.used_q   (used_q),
		.star_q   (star_q),
		.any_q    (any_q),
		.icase_q  (icase_q)
	);

	gwm_step #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.mid      (mid.source),
		.cfg_wr   (cfg_wr),
		.start_nx (start_nx),
		.start_q  (start_q),
		.fin_q    (fin_q),
		.pat_b_q  (pat_b_q),
		.pat_u_q  (pat_u_q),
		.used_q   (used_q),
		.star_q   (star_q),
		.any_q    (any_q),
		.icase_q  (icase_q)
	);

	gwm_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.mid    (mid.sink),
		.out_ch (out_ch)
	);

endmodule

// ===== verif/tb_glob_wildcard_matcher_core.sv =====
`timescale 1ns / 1ps

typedef enum logic {
	ITEM_CHAR = 1'b0,
	ITEM_END  = 1'b1
} item_kind_e;

// tracks the live pattern positions and the match bits still owed by the block
class match_tracker;
	logic [63:0]                     pat_words [4];
	logic [gwm_pkg::LEN_W-1:0]       pat_len;
	logic                            fold_case;
	logic [gwm_pkg::ACT_W_MAX-1:0]   live_set;
	logic                            pending_matches [$];
	int                              errors;

	function new();
		foreach (pat_words[i])
			pat_words[i] = '0;
		pat_len   = '0;
		fold_case = 1'b0;
		errors    = 0;
		restart();
	endfunction

	function logic [7:0] pat_char(int i);
		return pat_words[i >> 3][(i & 7) * 8 +: 8];
	endfunction

	// a zero byte cuts the pattern short, as does the size limit
	function int used_len();
		int lim;
		lim = pat_len;
		if (lim > gwm_pkg::PATTERN_MAX_DEF)
			lim = gwm_pkg::PATTERN_MAX_DEF;
		for (int i = 0; i < lim; i++)
			if (pat_char(i) == 8'h00)
				return i;
		return lim;
	endfunction

	function logic [7:0] upcase(logic [7:0] c);
		if (c >= gwm_pkg::LOWER_A && c <= gwm_pkg::LOWER_Z)
			return c - gwm_pkg::CASE_DELTA;
		return c;
	endfunction

	function logic [gwm_pkg::ACT_W_MAX-1:0] close_stars(logic [gwm_pkg::ACT_W_MAX-1:0] s, int n);
		for (int i = 0; i < n; i++)
			if (s[i] && pat_char(i) == gwm_pkg::STAR_CHAR)
				s[i+1] = 1'b1;
		return s;
	endfunction

	function void restart();
		live_set = close_stars(gwm_pkg::ACT_W_MAX'(1), used_len());
	endfunction

	function void write_reg(logic [gwm_pkg::INDEX_W-1:0] idx, logic [63:0] val);
		case (idx)
			gwm_pkg::REG_PAT0, gwm_pkg::REG_PAT1, gwm_pkg::REG_PAT2, gwm_pkg::REG_PAT3: begin
				pat_words[idx[1:0]] = val;
			end
			gwm_pkg::REG_LEN: begin
				pat_len = val[gwm_pkg::LEN_W-1:0];
			end
			gwm_pkg::REG_ICASE: begin
				fold_case = val[0];
			end
			default: begin
				return;
			end
		endcase
		restart();
	endfunction

	function void note_transfer(item_kind_e k, logic [7:0] c);
		logic [gwm_pkg::ACT_W_MAX-1:0] nxt;
		logic [7:0]                    p;
		int                            n;
		n = used_len();
		if (k == ITEM_END) begin
			pending_matches.push_back(live_set[n]);
			restart();
			return;
		end
		nxt = '0;
		for (int i = 0; i < n; i++) begin
			if (live_set[i]) begin
				p = pat_char(i);
				if (p == gwm_pkg::STAR_CHAR)
					nxt[i] = 1'b1;
				else if (p == gwm_pkg::ANY_CHAR || p == c || (fold_case && upcase(p) == upcase(c)))
					nxt[i+1] = 1'b1;
			end
		end
		live_set = close_stars(nxt, n);
	endfunction

	function void check_match(logic got);
		logic want;
		if (pending_matches.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: matched=%b arrived with no string waiting", got);
			return;
		end
		want = pending_matches.pop_front();
		if (got !== want) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: matched expected %b, got %b", want, got);
		end
	endfunction

	function int pending();
		return pending_matches.size();
	endfunction
endclass

module tb_glob_wildcard_matcher_core;
	import gwm_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 950;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	gwm_in_if  in_ch();
	gwm_out_if out_ch();

	match_tracker sb;

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int rx_hold_left = 0;
	int sent_items   = 0;
	int quiet_cycles = 0;

	glob_wildcard_matcher_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready)
			sb.check_match(out_ch.matched);
		if (in_ch.valid && in_ch.ready)
			sb.note_transfer(item_kind_e'(in_ch.kind), in_ch.subject_char);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// result side: random back-pressure, or a long hold-off when asked
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				out_ch.ready <= 1'b0;
				rx_hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	task automatic apb_write(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input item_kind_e k, input logic [7:0] c);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid        <= 1'b1;
		in_ch.kind         <= k;
		in_ch.subject_char <= c;
		do @(posedge clk); while (!in_ch.ready);
		sent_items++;
	endtask

	// stop offering and let the block drain before touching its registers
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (6) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return LOWER_A;
			1: return 8'h62;
			2: return 8'h41;
			3: return 8'h42;
			4: return LOWER_Z;
			5: return 8'h5A;
			6: return 8'h40;
			7: return 8'h7B;
			8: return STAR_CHAR;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic load_random_pattern();
		logic [DATA_W-1:0] words [4];
		logic [DATA_W-1:0] len_word;
		logic [7:0]        b;
		int                n;
		case ($urandom_range(0, 9))
			0: n = 0;
			1: n = PAT_LIMIT;
			default: n = $urandom_range(1, 10);
		endcase
		for (int i = 0; i < PAT_LIMIT; i++) begin
			if (i >= n)
				b = 8'($urandom_range(0, 255));
			else if ($urandom_range(0, 5) < 2)
				b = STAR_CHAR;
			else if ($urandom_range(0, 3) == 0)
				b = ANY_CHAR;
			else
				b = pick_char();
			words[i >> 3][(i & 7) * 8 +: 8] = b;
		end
		// now and then a zero byte inside, or one word of pure noise
		if ($urandom_range(0, 15) == 0 && n > 0)
			words[0][$urandom_range(0, 7) * 8 +: 8] = 8'h00;
		if ($urandom_range(0, 15) == 0)
			words[$urandom_range(0, 3)] = {$urandom, $urandom};
		len_word = DATA_W'(n);
		if (n == PAT_LIMIT && $urandom_range(0, 1))
			len_word = DATA_W'($urandom_range(33, 63));
		if ($urandom_range(0, 3) == 0)
			len_word[DATA_W-1:LEN_W] = (DATA_W-LEN_W)'({$urandom, $urandom});
		apb_write(REG_PAT0, words[0]);
		apb_write(REG_PAT1, words[1]);
		apb_write(REG_PAT2, words[2]);
		apb_write(REG_PAT3, words[3]);
		apb_write(REG_LEN, len_word);
		apb_write(REG_ICASE, {$urandom, $urandom});
	endtask

	// mostly strings shaped after the pattern with a little damage, the rest noise
	task automatic send_string();
		logic [7:0] subj [$];
		logic [7:0] p;
		int         n;
		n = sb.used_len();
		if ($urandom_range(0, 3) != 0) begin
			for (int i = 0; i < n; i++) begin
				p = sb.pat_char(i);
				if (p == STAR_CHAR)
					repeat ($urandom_range(0, 3)) subj.push_back(pick_char());
				else if (p == ANY_CHAR)
					subj.push_back(8'($urandom_range(0, 255)));
				else if (sb.fold_case && $urandom_range(0, 1) &&
				         (p | CASE_DELTA) >= LOWER_A && (p | CASE_DELTA) <= LOWER_Z)
					subj.push_back(p ^ CASE_DELTA);
				else
					subj.push_back(p);
			end
			if ($urandom_range(0, 3) == 0 && subj.size() > 0)
				subj[$urandom_range(0, subj.size() - 1)] = pick_char();
			if ($urandom_range(0, 7) == 0)
				subj.push_back(pick_char());
			if ($urandom_range(0, 7) == 0 && subj.size() > 0)
				subj.delete($urandom_range(0, subj.size() - 1));
		end else begin
			repeat ($urandom_range(0, 6))
				subj.push_back($urandom_range(0, 1) ? pick_char() : 8'($urandom_range(0, 255)));
		end
		foreach (subj[i])
			send_item(ITEM_CHAR, subj[i]);
		send_item(ITEM_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int phase;
		int target;
		sb = new();
		arst_n             = 1'b0;
		psel               <= 1'b0;
		penable            <= 1'b0;
		pwrite             <= 1'b0;
		paddr              <= '0;
		pwdata             <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.kind         <= ITEM_CHAR;
		in_ch.subject_char <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern out of reset: only the empty string matches
		send_item(ITEM_END, 8'h00);
		send_item(ITEM_END, 8'hFF);
		send_item(ITEM_CHAR, 8'hFF);
		send_item(ITEM_END, 8'h00);
		drain();

		// "a?*B" with case folding, junk past the length
		apb_write(REG_PAT0, 64'h5A5A_5A5A_422A_3F61);
		apb_write(REG_PAT1, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_PAT2, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_PAT3, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_LEN, 64'd4);
		apb_write(REG_ICASE, 64'd1);
		send_item(ITEM_CHAR, 8'h41);
		send_item(ITEM_CHAR, 8'h00);
		send_item(ITEM_CHAR, 8'hFF);
		send_item(ITEM_CHAR, 8'h62);
		send_item(ITEM_END, 8'h00);
		send_item(ITEM_CHAR, LOWER_A);
		send_item(ITEM_CHAR, LOWER_Z);
		send_item(ITEM_END, 8'h00);
		drain();
		apb_write(REG_ICASE, 64'd0);
		send_item(ITEM_CHAR, 8'h41);
		send_item(ITEM_END, 8'h00);
		send_item(ITEM_END, 8'h00);
		drain();

		// zero byte ends "*?" early, length above the limit
		apb_write(REG_PAT0, 64'hFFFF_FFFF_FF00_3F2A);
		apb_write(REG_LEN, 64'd63);
		send_item(ITEM_CHAR, 8'h80);
		send_item(ITEM_END, 8'h00);
		send_item(ITEM_END, 8'h00);
		drain();

		// thirty-two stars
		apb_write(REG_PAT0, 64'h2A2A_2A2A_2A2A_2A2A);
		apb_write(REG_PAT1, 64'h2A2A_2A2A_2A2A_2A2A);
		apb_write(REG_PAT2, 64'h2A2A_2A2A_2A2A_2A2A);
		apb_write(REG_PAT3, 64'h2A2A_2A2A_2A2A_2A2A);
		send_item(ITEM_END, 8'h00);
		send_item(ITEM_CHAR, 8'h01);
		send_item(ITEM_END, 8'h00);

		target = sent_items + RANDOM_ITEMS;
		phase  = 0;
		while (sent_items < target) begin
			drain();
			case (phase % 5)
				0: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 0;
				end
				1: begin
					tx_idle_pct  = 72;
					rx_stall_pct = 0;
				end
				2: begin
					tx_idle_pct  = 0;
					rx_stall_pct = 72;
				end
				3: begin
					tx_idle_pct  = 24;
					rx_stall_pct = 24;
				end
				default: begin
					tx_idle_pct  = $urandom_range(0, 40);
					rx_stall_pct = $urandom_range(0, 40);
				end
			endcase
			load_random_pattern();
			// long result hold-off while strings keep coming, so the input backs up
			if (phase % 10 == 4)
				rx_hold_left = 300;
			for (int s = 0; s < 8; s++) begin
				if (s == 3 && phase % 10 == 7) begin
					in_ch.valid <= 1'b0;
					do @(posedge clk); while (sb.pending() != 0);
				end
				send_string();
			end
			phase++;
		end

		drain();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// ===== files.f =====
sv/gwm_pkg.sv
sv/gwm_in_if.sv
sv/gwm_out_if.sv
sv/gwm_cfg.sv
sv/gwm_step.sv
sv/gwm_out.sv
sv/glob_wildcard_matcher_core.sv
verif/tb_glob_wildcard_matcher_core.sv
